>>> rtl/core/stt_pkg.sv
// Package for the source text tokenizer: token kinds, scan modes, token
// record type and the character-class and keyword lookup functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stt_pkg;

   localparam int POS_W = 16;
   localparam int OFF_W = 24;
   localparam int KW_CHARS = 8;
   localparam int LEN_W = 16;
   localparam int KIND_W = 6;
   localparam int TDATA_W = 80;

   localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd15;
   localparam logic [KIND_W-1:0] KIND_INT     = 6'd16;
   localparam logic [KIND_W-1:0] KIND_STRING  = 6'd17;
   localparam logic [KIND_W-1:0] KIND_ASSIGN  = 6'd18;
   localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd19;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd20;
   localparam logic [KIND_W-1:0] KIND_STAR    = 6'd21;
   localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd22;
   localparam logic [KIND_W-1:0] KIND_PERCENT = 6'd23;
   localparam logic [KIND_W-1:0] KIND_BANG    = 6'd24;
   localparam logic [KIND_W-1:0] KIND_LT      = 6'd25;
   localparam logic [KIND_W-1:0] KIND_GT      = 6'd26;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd27;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd28;
   localparam logic [KIND_W-1:0] KIND_LBRACE  = 6'd29;
   localparam logic [KIND_W-1:0] KIND_RBRACE  = 6'd30;
   localparam logic [KIND_W-1:0] KIND_LBRACK  = 6'd31;
   localparam logic [KIND_W-1:0] KIND_RBRACK  = 6'd32;
   localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd33;
   localparam logic [KIND_W-1:0] KIND_SEMI    = 6'd34;
   localparam logic [KIND_W-1:0] KIND_COLON   = 6'd35;
   localparam logic [KIND_W-1:0] KIND_EQ      = 6'd36;
   localparam logic [KIND_W-1:0] KIND_NE      = 6'd37;
   localparam logic [KIND_W-1:0] KIND_LE      = 6'd38;
   localparam logic [KIND_W-1:0] KIND_GE      = 6'd39;
   localparam logic [KIND_W-1:0] KIND_AND     = 6'd40;
   localparam logic [KIND_W-1:0] KIND_OR      = 6'd41;
   localparam logic [KIND_W-1:0] KIND_ADD_EQ  = 6'd42;
   localparam logic [KIND_W-1:0] KIND_SUB_EQ  = 6'd43;
   localparam logic [KIND_W-1:0] KIND_INC     = 6'd44;
   localparam logic [KIND_W-1:0] KIND_DEC     = 6'd45;
   localparam logic [KIND_W-1:0] KIND_END     = 6'd46;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 6'd47;
   localparam logic [KIND_W-1:0] KIND_NONE    = 6'd63;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_WORD, MODE_NUMBER, MODE_STRING, MODE_OPER, MODE_LINE, MODE_BLOCK
   } mode_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [OFF_W-1:0]  offset;
      logic [POS_W-1:0]  column;
      logic [POS_W-1:0]  line;
      logic [KIND_W-1:0] kind;
      logic              last;
   } token_type;

   localparam logic [63:0] KW_TEXT [15] = '{
      64'h74656c, 64'h6e66, 64'h6e7275746572, 64'h6669, 64'h65736c65,
      64'h656c696877, 64'h726f66, 64'h746e697270, 64'h7475706e69,
      64'h7265626d756e7369, 64'h676e697274737369, 64'h74697865,
      64'h736261, 64'h65757274, 64'h65736c6166};
   localparam logic [3:0] KW_LEN [15] = '{
      4'd3, 4'd2, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd5, 4'd5, 4'd8, 4'd8, 4'd4, 4'd3,
      4'd4, 4'd5};

   function automatic logic [KIND_W-1:0] word_kind(input logic [63:0] buf_v,
                                                   input logic [LEN_W-1:0] len);
      logic [KIND_W-1:0] k;
      k = KIND_IDENT;
      for (int i = 14; i >= 0; i--) begin
         if (len == LEN_W'(KW_LEN[i]) && buf_v == KW_TEXT[i]) k = KIND_W'(i);
      end
      return k;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   // KIND_NONE when the byte cannot open a two-character operator
   function automatic logic [KIND_W-1:0] lone_kind(input logic [7:0] p);
      case (p)
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         "=":     return KIND_ASSIGN;
         "!":     return KIND_BANG;
         "<":     return KIND_LT;
         ">":     return KIND_GT;
         "/":     return KIND_SLASH;
         "&":     return KIND_UNKNOWN;
         "|":     return KIND_UNKNOWN;
         default: return KIND_NONE;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
      logic [KIND_W-1:0] k;
      k = KIND_NONE;
      if (p == "+" && c == "=") k = KIND_ADD_EQ;
      else if (p == "+" && c == "+") k = KIND_INC;
      else if (p == "-" && c == "=") k = KIND_SUB_EQ;
      else if (p == "-" && c == "-") k = KIND_DEC;
      else if (c == "=" && p == "=") k = KIND_EQ;
      else if (c == "=" && p == "!") k = KIND_NE;
      else if (c == "=" && p == "<") k = KIND_LE;
      else if (c == "=" && p == ">") k = KIND_GE;
      else if (p == "&" && c == "&") k = KIND_AND;
      else if (p == "|" && c == "|") k = KIND_OR;
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
      case (c)
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         "[":     return KIND_LBRACK;
         "]":     return KIND_RBRACK;
         ",":     return KIND_COMMA;
         ";":     return KIND_SEMI;
         ":":     return KIND_COLON;
         "*":     return KIND_STAR;
         "%":     return KIND_PERCENT;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/stt_scan.sv
// Scan state registers and the single-pass next-state logic: one byte in,
// up to two finished tokens out. Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stt_scan (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_valid,
   input  wire logic [7:0]         byte_code,
   output stt_pkg::token_type      tok_0,
   output stt_pkg::token_type      tok_1,
   output logic [1:0]              tok_count
);
   import stt_pkg::*;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};
   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   mode_type         mode_ff, mode_in;
   logic [7:0]       pend_ff, pend_in;
   logic             esc_ff, esc_in;
   logic [63:0]      wbuf_ff, wbuf_in;
   logic [LEN_W-1:0] tlen_ff, tlen_in;
   logic [POS_W-1:0] line_ff, line_in, col_ff, col_in, sline_ff, sline_in, scol_ff, scol_in;
   logic [OFF_W-1:0] off_ff, off_in, soff_ff, soff_in;

   logic [POS_W-1:0] adv_line, adv_col;
   logic [OFF_W-1:0] adv_off;
   logic [LEN_W-1:0] tlen_inc;
   logic             go_idle, done;
   logic [KIND_W-1:0] pk;
   token_type        tok [2];
   logic [1:0]       n;
   logic [7:0]       c;

   assign c = byte_code;

   always_comb begin
      adv_line = line_ff;
      adv_col  = col_ff;
      if (c == 8'h0a) begin
         if (line_ff != POS_MAX) adv_line = line_ff + 1'b1;
         adv_col = POS_W'(1);
      end else if (col_ff != POS_MAX) begin
         adv_col = col_ff + 1'b1;
      end
      adv_off  = (off_ff != OFF_MAX) ? off_ff + 1'b1 : off_ff;
      tlen_inc = (tlen_ff != LEN_MAX) ? tlen_ff + 1'b1 : tlen_ff;
   end

   always_comb begin
      mode_in = mode_ff;  pend_in = pend_ff;  esc_in = esc_ff;
      wbuf_in = wbuf_ff;  tlen_in = tlen_ff;
      line_in = line_ff;  col_in = col_ff;    off_in = off_ff;
      sline_in = sline_ff; scol_in = scol_ff; soff_in = soff_ff;
      tok[0] = '0;  tok[1] = '0;
      n = 2'd0;  go_idle = 1'b0;  done = 1'b0;
      pk = pair_kind(pend_ff, c);

      case (mode_ff)
         MODE_WORD: begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
               if (tlen_ff < LEN_W'(KW_CHARS)) wbuf_in[8*tlen_ff[2:0] +: 8] = c;
               tlen_in = tlen_inc;
               done = 1'b1;
            end else begin
               tok[0] = '{len: tlen_ff, offset: soff_ff, column: scol_ff, line: sline_ff,
                          kind: (tlen_ff > LEN_W'(KW_CHARS)) ? KIND_IDENT
                                : word_kind(wbuf_ff, tlen_ff), last: 1'b0};
               n = 2'd1;  mode_in = MODE_IDLE;  go_idle = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               tlen_in = tlen_inc;
               done = 1'b1;
            end else begin
               tok[0] = '{len: tlen_ff, offset: soff_ff, column: scol_ff, line: sline_ff,
                          kind: KIND_INT, last: 1'b0};
               n = 2'd1;  mode_in = MODE_IDLE;  go_idle = 1'b1;
            end
         end
         MODE_STRING: begin
            tok[0] = '{len: tlen_ff, offset: soff_ff, column: scol_ff, line: sline_ff,
                       kind: KIND_STRING, last: 1'b0};
            if (c == 8'h00) begin
               n = 2'd1;  mode_in = MODE_IDLE;  go_idle = 1'b1;
            end else if (c == "\"" && !esc_ff) begin
               n = 2'd1;  mode_in = MODE_IDLE;  done = 1'b1;
            end else begin
               esc_in  = (c == "\\");
               tlen_in = tlen_inc;
               done = 1'b1;
            end
         end
         MODE_OPER: begin
            if (pend_ff == "/" && c == "/") begin
               mode_in = MODE_LINE;  done = 1'b1;
            end else if (pend_ff == "/" && c == "*") begin
               mode_in = MODE_BLOCK;  esc_in = 1'b0;  done = 1'b1;
            end else begin
               mode_in = MODE_IDLE;
               pend_in = 8'h00;
               tok[0] = '{len: LEN_W'(2), offset: soff_ff, column: scol_ff, line: sline_ff,
                          kind: pk, last: 1'b0};
               n = 2'd1;
               if (pk != KIND_NONE) begin
                  done = 1'b1;
               end else begin
                  tok[0].len  = LEN_W'(1);
                  tok[0].kind = (lone_kind(pend_ff) != KIND_NONE) ? lone_kind(pend_ff)
                                                                 : KIND_UNKNOWN;
                  go_idle = 1'b1;
               end
            end
         end
         MODE_LINE: begin
            if (c == 8'h00 || c == 8'h0a) begin
               mode_in = MODE_IDLE;  go_idle = 1'b1;
            end else begin
               done = 1'b1;
            end
         end
         MODE_BLOCK: begin
            if (c == 8'h00) begin
               mode_in = MODE_IDLE;  esc_in = 1'b0;  go_idle = 1'b1;
            end else begin
               if (esc_ff && c == "/") begin
                  mode_in = MODE_IDLE;  esc_in = 1'b0;
               end else begin
                  esc_in = (c == "*");
               end
               done = 1'b1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;  go_idle = 1'b1;
         end
      endcase

      if (done) begin
         line_in = adv_line;  col_in = adv_col;  off_in = adv_off;
      end

      if (go_idle) begin
         if (c == 8'h00) begin
            // end token at the current position, then back to reset state
            tok[n[0]] = '{len: '0, offset: off_ff, column: col_ff, line: line_ff,
                          kind: KIND_END, last: 1'b0};
            n = n + 2'd1;
            mode_in = MODE_IDLE;  pend_in = 8'h00;  esc_in = 1'b0;  wbuf_in = '0;
            tlen_in = '0;  line_in = POS_W'(1);  col_in = POS_W'(1);  off_in = '0;
            sline_in = '0;  scol_in = '0;  soff_in = '0;
         end else begin
            line_in = adv_line;  col_in = adv_col;  off_in = adv_off;
            if (!is_space(c)) begin
               sline_in = line_ff;  scol_in = col_ff;  soff_in = off_ff;
               if (is_digit(c)) begin
                  tlen_in = LEN_W'(1);  mode_in = MODE_NUMBER;
               end else if (is_alpha(c) || c == "_") begin
                  wbuf_in = {56'h0, c};  tlen_in = LEN_W'(1);  mode_in = MODE_WORD;
               end else if (c == "\"") begin
                  soff_in = adv_off;  tlen_in = '0;  esc_in = 1'b0;  mode_in = MODE_STRING;
               end else if (lone_kind(c) != KIND_NONE) begin
                  pend_in = c;  mode_in = MODE_OPER;
               end else begin
                  tok[n[0]] = '{len: LEN_W'(1), offset: off_ff, column: col_ff,
                                line: line_ff, kind: single_kind(c), last: 1'b0};
                  n = n + 2'd1;
               end
            end
         end
      end

      if (n == 2'd1) tok[0].last = 1'b1;
      if (n == 2'd2) tok[1].last = 1'b1;
   end

   assign tok_0 = tok[0];
   assign tok_1 = tok[1];
   assign tok_count = byte_valid ? n : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;  pend_ff <= 8'h00;  esc_ff <= 1'b0;  wbuf_ff <= '0;
         tlen_ff <= '0;  line_ff <= POS_W'(1);  col_ff <= POS_W'(1);  off_ff <= '0;
         sline_ff <= '0;  scol_ff <= '0;  soff_ff <= '0;
      end else if (byte_valid) begin
         mode_ff <= mode_in;  pend_ff <= pend_in;  esc_ff <= esc_in;  wbuf_ff <= wbuf_in;
         tlen_ff <= tlen_in;  line_ff <= line_in;  col_ff <= col_in;  off_ff <= off_in;
         sline_ff <= sline_in;  scol_ff <= scol_in;  soff_ff <= soff_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/stt_queue.sv
// Four-entry result queue: takes up to two tokens a cycle, gives one.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stt_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stt_pkg::token_type push_0,
   input  wire stt_pkg::token_type push_1,
   input  wire logic [1:0]         push_count,
   output logic                    room_two,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output stt_pkg::token_type      pop_data
);
   import stt_pkg::*;

   token_type  store [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = cnt_ff != 3'd0;
   assign pop_data  = store[rp_ff];
   assign room_two  = cnt_ff <= 3'd2;
   assign wp_in     = wp_ff + push_count;
   assign rp_in     = rp_ff + {1'b0, pop};
   assign cnt_in    = cnt_ff + {1'b0, push_count} - {2'b0, pop};

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) store[wp_ff] <= push_0;
      if (push_count == 2'd2) store[wp_ff + 2'd1] <= push_1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;  rp_ff <= '0;  cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;  rp_ff <= rp_in;  cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/source_text_tokenizer_core.sv
// Source text tokenizer, top level: byte stream in, token stream out.
// Depends on stt_pkg, stt_scan and stt_queue.
// Output: a token that ends on a byte beat is written into the result queue, whose
// head drives rsp. Throughput: one byte beat per cycle while the four-entry result
// queue has room for two tokens; the queue drains one token per cycle while rsp_tready is high.
// Reset: synchronous, active high; scan state to idle, line and column 1.
`timescale 1ns / 1ps
`default_nettype none
module source_text_tokenizer_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,   // [7:0] char_code
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [stt_pkg::TDATA_W-1:0]    rsp_tdata,   // token_kind, start_line,
                                                       // start_column, text_offset,
                                                       // text_length, zero pad
   output logic                           rsp_tlast    // last token caused by one byte beat
);
   import stt_pkg::*;

   token_type  tok_0, tok_1, head;
   logic [1:0] tok_count;
   logic       room_two, byte_take;

   // take a byte only when both possible tokens of it fit in the queue
   assign req_tready = room_two;
   assign byte_take  = req_tvalid && req_tready;

   stt_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(byte_take),
      .byte_code (req_tdata),
      .tok_0     (tok_0),
      .tok_1     (tok_1),
      .tok_count (tok_count)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_0    (tok_0),
      .push_1    (tok_1),
      .push_count(tok_count),
      .room_two  (room_two),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (head)
   );

   // pack fields from the lowest bit up, pad to whole bytes
   assign rsp_tdata = {2'b00, head.len, head.offset, head.column, head.line, head.kind};
   assign rsp_tlast = head.last;

endmodule
`default_nettype wire

>>> rtl/core/stt_checker.sv
// Port-level checker for the tokenizer top level, with its bind.
// Depends on source_text_tokenizer_core ports only.
`timescale 1ns / 1ps
`default_nettype none
module stt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:0] <= 6'd47)
      else $error("token kind out of range");

   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5:0] == 6'd46 |-> rsp_tlast && rsp_tdata[77:62] == 16'd0)
      else $error("end token not last or has length");

   a_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5:0] != 6'd46 |-> rsp_tdata[21:6] != 16'd0
                                             && rsp_tdata[37:22] != 16'd0)
      else $error("token position zero");
endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast));
`default_nettype wire
